FILE: rtl/core/assert_macros.svh
// Assertion macros for the orbit camera block, used by its top-level RTL file.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OCEP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OCEP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ocep_pkg.sv
// Package for the orbit camera eye position block: widths, angle constants,
// register codes and the CORDIC arctangent table. No dependencies.
package ocep_pkg;

  localparam int COORD_W       = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                : ATAN_ENTRIES;

  localparam int ANG_IN_W  = 18;
  localparam int ANG_W     = 16;
  localparam int ANG_FRAC  = 13;
  localparam int DIST_W    = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_Q30 = 30;
  localparam int XY_W     = 33;
  localparam int Z_W      = 34;
  localparam int Z_SHIFT  = FRAC_Q30 - ANG_FRAC;
  localparam int TRIG_W   = 32;
  localparam int PROD_W   = 2 * TRIG_W;
  localparam int SCALE_W  = PROD_W - FRAC_Q30;
  localparam int EYE_W    = ((COORD_W > SCALE_W) ? COORD_W : SCALE_W) + 1;

  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  localparam int HALF_PI_Q13 = 12868;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(32'h26DD3B6A);

  localparam logic signed [ANG_W-1:0] PITCH_MIN_RST = -16'sd6434;
  localparam logic signed [ANG_W-1:0] PITCH_MAX_RST = 16'sd6434;
  localparam logic [DIST_W-1:0]       DIST_RST      = 31'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_MIN  = 2'd0,
    REG_PITCH_MAX  = 2'd1,
    REG_ORBIT_DIST = 2'd2
  } cfg_reg_t;

  // Floor of atan(2^-i) in Q2.30.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return $signed({{(Z_W-32){1'b0}}, v});
  endfunction

endpackage

FILE: rtl/core/ocep_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on ocep_pkg for widths, the start vector and the arctangent table.
module ocep_cordic (
  input  logic                             clk,
  input  logic [ocep_pkg::CORDIC_RUN-1:0]  en,
  input  logic signed [ocep_pkg::Z_W-1:0]  z_in,
  output logic signed [ocep_pkg::XY_W-1:0] x_out,
  output logic signed [ocep_pkg::XY_W-1:0] y_out
);
  import ocep_pkg::*;

  logic signed [XY_W-1:0] x_r [CORDIC_RUN];
  logic signed [XY_W-1:0] y_r [CORDIC_RUN];
  logic signed [Z_W-1:0]  z_r [CORDIC_RUN];

  for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_stage
    logic signed [XY_W-1:0] x_prev;
    logic signed [XY_W-1:0] y_prev;
    logic signed [Z_W-1:0]  z_prev;

    if (i == 0) begin : g_first
      assign x_prev = CORDIC_X0;
      assign y_prev = '0;
      assign z_prev = z_in;
    end else begin : g_rest
      assign x_prev = x_r[i-1];
      assign y_prev = y_r[i-1];
      assign z_prev = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!z_prev[Z_W-1]) begin
          x_r[i] <= x_prev - (y_prev >>> i);
          y_r[i] <= y_prev + (x_prev >>> i);
          z_r[i] <= z_prev - atan_q30(i);
        end else begin
          x_r[i] <= x_prev + (y_prev >>> i);
          y_r[i] <= y_prev - (x_prev >>> i);
          z_r[i] <= z_prev + atan_q30(i);
        end
      end
    end
  end

  assign x_out = x_r[CORDIC_RUN-1];
  assign y_out = y_r[CORDIC_RUN-1];

endmodule

FILE: rtl/core/orbit_camera_eye_position.sv
// Orbit camera eye position: a fully pipelined unit that takes one item per clock while
// in_ready is high and returns one result item per input item, in order. Its stages are
// the two parallel CORDIC pipelines for pitch and yaw (with the default 16 CORDIC
// stages), plus stages for angle correction, quadrant fold, sign fix, two multiplies
// with rounding, and the final subtract and saturate. Stalls on the output side back
// up only as far as needed; empty stages keep filling. Configuration writes take
// effect at once and should only be made while no item is in flight.
// Depends on ocep_pkg, ocep_cordic and assert_macros.svh.
`include "assert_macros.svh"

module orbit_camera_eye_position (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ocep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ocep_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ocep_pkg::ANG_IN_W-1:0] yaw_in,
  input  logic signed [ocep_pkg::ANG_IN_W-1:0] pitch_in,
  input  logic signed [ocep_pkg::COORD_W-1:0]  target_x,
  input  logic signed [ocep_pkg::COORD_W-1:0]  target_y,
  input  logic signed [ocep_pkg::COORD_W-1:0]  target_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ocep_pkg::COORD_W-1:0]  eye_x,
  output logic signed [ocep_pkg::COORD_W-1:0]  eye_y,
  output logic signed [ocep_pkg::COORD_W-1:0]  eye_z,
  output logic signed [ocep_pkg::ANG_W-1:0]    yaw_out,
  output logic signed [ocep_pkg::ANG_W-1:0]    pitch_out
);
  import ocep_pkg::*;

  localparam int ST_WRAP  = 0;
  localparam int ST_FOLD  = 1;
  localparam int ST_CORD0 = 2;
  localparam int ST_NEG   = ST_CORD0 + CORDIC_RUN;
  localparam int ST_MUL1  = ST_NEG + 1;
  localparam int ST_RND   = ST_NEG + 2;
  localparam int ST_MUL2  = ST_NEG + 3;
  localparam int ST_OUT   = ST_NEG + 4;
  localparam int NSTG     = ST_OUT + 1;

  localparam logic signed [ANG_IN_W:0]   PI_W      = (ANG_IN_W+1)'(PI_Q13);
  localparam logic signed [ANG_IN_W:0]   TWO_PI_W  = (ANG_IN_W+1)'(TWO_PI_Q13);
  localparam logic signed [ANG_W-1:0]    PI_A      = ANG_W'(PI_Q13);
  localparam logic signed [ANG_W-1:0]    HALF_PI_A = ANG_W'(HALF_PI_Q13);
  localparam logic signed [PROD_W-1:0]   RND_HALF  = PROD_W'(1) << (FRAC_Q30 - 1);
  localparam logic signed [COORD_W-1:0]  COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]  COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ANG_W-1:0]   yaw;
    logic signed [ANG_W-1:0]   pitch;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
    logic                      neg_p;
    logic                      neg_y;
  } side_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [EYE_W-1:0] e
  );
    logic hi_same;
    hi_same = (e[EYE_W-1:COORD_W-1] == '0) || (e[EYE_W-1:COORD_W-1] == '1);
    if (hi_same) begin
      return e[COORD_W-1:0];
    end
    return e[EYE_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  // Configuration registers.
  logic signed [ANG_W-1:0] pitch_min;
  logic signed [ANG_W-1:0] pitch_max;
  logic [DIST_W-1:0]       orbit_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_min      <= PITCH_MIN_RST;
      pitch_max      <= PITCH_MAX_RST;
      orbit_distance <= DIST_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PITCH_MIN:  pitch_min      <= cfg_data[ANG_W-1:0];
        REG_PITCH_MAX:  pitch_max      <= cfg_data[ANG_W-1:0];
        REG_ORBIT_DIST: orbit_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      en[i] = out_ready || (((~vld) >> i) != '0);
    end
  end

  assign in_ready  = en[ST_WRAP];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Pitch clamp, and a single yaw wrap followed by a clamp to [-pi, pi].
  side_t side_wrap;

  always_comb begin
    logic signed [ANG_IN_W-1:0] p_c;
    logic signed [ANG_IN_W:0]   y_w;
    p_c = pitch_in;
    if (p_c < ANG_IN_W'(pitch_min)) begin
      p_c = ANG_IN_W'(pitch_min);
    end
    if (p_c > ANG_IN_W'(pitch_max)) begin
      p_c = ANG_IN_W'(pitch_max);
    end
    y_w = (ANG_IN_W+1)'(yaw_in);
    if (y_w < -PI_W) begin
      y_w = y_w + TWO_PI_W;
    end
    if (y_w > PI_W) begin
      y_w = y_w - TWO_PI_W;
    end
    if (y_w < -PI_W) begin
      y_w = -PI_W;
    end
    if (y_w > PI_W) begin
      y_w = PI_W;
    end
    side_wrap.yaw   = y_w[ANG_W-1:0];
    side_wrap.pitch = p_c[ANG_W-1:0];
    side_wrap.tx    = target_x;
    side_wrap.ty    = target_y;
    side_wrap.tz    = target_z;
    side_wrap.neg_p = 1'b0;
    side_wrap.neg_y = 1'b0;
  end

  side_t side [NSTG];

  // Quadrant fold into [-pi/2, pi/2] and conversion to a Q2.30 angle.
  logic signed [ANG_W-1:0] pitch_f;
  logic signed [ANG_W-1:0] yaw_f;
  logic                    neg_p_f;
  logic                    neg_y_f;
  side_t                   side_fold;
  logic signed [Z_W-1:0]   z_p;
  logic signed [Z_W-1:0]   z_y;

  always_comb begin
    pitch_f = side[ST_WRAP].pitch;
    neg_p_f = 1'b0;
    if (side[ST_WRAP].pitch > HALF_PI_A) begin
      pitch_f = side[ST_WRAP].pitch - PI_A;
      neg_p_f = 1'b1;
    end else if (side[ST_WRAP].pitch < -HALF_PI_A) begin
      pitch_f = side[ST_WRAP].pitch + PI_A;
      neg_p_f = 1'b1;
    end
    yaw_f   = side[ST_WRAP].yaw;
    neg_y_f = 1'b0;
    if (side[ST_WRAP].yaw > HALF_PI_A) begin
      yaw_f   = side[ST_WRAP].yaw - PI_A;
      neg_y_f = 1'b1;
    end else if (side[ST_WRAP].yaw < -HALF_PI_A) begin
      yaw_f   = side[ST_WRAP].yaw + PI_A;
      neg_y_f = 1'b1;
    end
    side_fold       = side[ST_WRAP];
    side_fold.neg_p = neg_p_f;
    side_fold.neg_y = neg_y_f;
  end

  always_ff @(posedge clk) begin
    if (en[ST_WRAP]) begin
      side[ST_WRAP] <= side_wrap;
    end
    if (en[ST_FOLD]) begin
      side[ST_FOLD] <= side_fold;
    end
    for (int i = ST_FOLD + 1; i < NSTG; i++) begin
      if (en[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_FOLD]) begin
      z_p <= Z_W'(pitch_f) <<< Z_SHIFT;
      z_y <= Z_W'(yaw_f) <<< Z_SHIFT;
    end
  end

  logic signed [XY_W-1:0] cos_p_raw;
  logic signed [XY_W-1:0] sin_p_raw;
  logic signed [XY_W-1:0] cos_y_raw;
  logic signed [XY_W-1:0] sin_y_raw;

  ocep_cordic u_cordic_pitch (
    .clk   (clk),
    .en    (en[ST_CORD0 +: CORDIC_RUN]),
    .z_in  (z_p),
    .x_out (cos_p_raw),
    .y_out (sin_p_raw)
  );

  ocep_cordic u_cordic_yaw (
    .clk   (clk),
    .en    (en[ST_CORD0 +: CORDIC_RUN]),
    .z_in  (z_y),
    .x_out (cos_y_raw),
    .y_out (sin_y_raw)
  );

  // Undo the fold by negating sine and cosine.
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;
  logic signed [TRIG_W-1:0] sy;
  logic signed [TRIG_W-1:0] cy;
  logic signed [XY_W-1:0]   sp_next;
  logic signed [XY_W-1:0]   cp_next;
  logic signed [XY_W-1:0]   sy_next;
  logic signed [XY_W-1:0]   cy_next;

  always_comb begin
    sp_next = side[ST_NEG-1].neg_p ? -sin_p_raw : sin_p_raw;
    cp_next = side[ST_NEG-1].neg_p ? -cos_p_raw : cos_p_raw;
    sy_next = side[ST_NEG-1].neg_y ? -sin_y_raw : sin_y_raw;
    cy_next = side[ST_NEG-1].neg_y ? -cos_y_raw : cos_y_raw;
  end

  always_ff @(posedge clk) begin
    if (en[ST_NEG]) begin
      sp <= sp_next[TRIG_W-1:0];
      cp <= cp_next[TRIG_W-1:0];
      sy <= sy_next[TRIG_W-1:0];
      cy <= cy_next[TRIG_W-1:0];
    end
  end

  // Forward vector products.
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_z;
  logic signed [TRIG_W-1:0] sp_m;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1]) begin
      prod_x <= PROD_W'(sy) * PROD_W'(cp);
      prod_z <= PROD_W'(cy) * PROD_W'(cp);
      sp_m   <= sp;
    end
  end

  logic signed [TRIG_W-1:0] fwd_x;
  logic signed [TRIG_W-1:0] fwd_y;
  logic signed [TRIG_W-1:0] fwd_z;
  logic signed [PROD_W-1:0] prod_x_h;
  logic signed [PROD_W-1:0] prod_z_h;

  assign prod_x_h = prod_x + RND_HALF;
  assign prod_z_h = prod_z + RND_HALF;

  always_ff @(posedge clk) begin
    if (en[ST_RND]) begin
      fwd_x <= prod_x_h[FRAC_Q30+TRIG_W-1:FRAC_Q30];
      fwd_y <= -sp_m;
      fwd_z <= prod_z_h[FRAC_Q30+TRIG_W-1:FRAC_Q30];
    end
  end

  // Scale by the orbit distance.
  logic signed [DIST_W:0]   dist_s;
  logic signed [PROD_W-1:0] off_x;
  logic signed [PROD_W-1:0] off_y;
  logic signed [PROD_W-1:0] off_z;

  assign dist_s = $signed({1'b0, orbit_distance});

  always_ff @(posedge clk) begin
    if (en[ST_MUL2]) begin
      off_x <= PROD_W'(fwd_x) * PROD_W'(dist_s);
      off_y <= PROD_W'(fwd_y) * PROD_W'(dist_s);
      off_z <= PROD_W'(fwd_z) * PROD_W'(dist_s);
    end
  end

  // Round, subtract from the target and saturate.
  logic signed [PROD_W-1:0]  off_x_h;
  logic signed [PROD_W-1:0]  off_y_h;
  logic signed [PROD_W-1:0]  off_z_h;
  logic signed [SCALE_W-1:0] scl_x;
  logic signed [SCALE_W-1:0] scl_y;
  logic signed [SCALE_W-1:0] scl_z;
  logic signed [EYE_W-1:0]   eye_x_next;
  logic signed [EYE_W-1:0]   eye_y_next;
  logic signed [EYE_W-1:0]   eye_z_next;

  always_comb begin
    off_x_h    = off_x + RND_HALF;
    off_y_h    = off_y + RND_HALF;
    off_z_h    = off_z + RND_HALF;
    scl_x      = off_x_h[PROD_W-1:FRAC_Q30];
    scl_y      = off_y_h[PROD_W-1:FRAC_Q30];
    scl_z      = off_z_h[PROD_W-1:FRAC_Q30];
    eye_x_next = EYE_W'(side[ST_OUT-1].tx) - EYE_W'(scl_x);
    eye_y_next = EYE_W'(side[ST_OUT-1].ty) - EYE_W'(scl_y);
    eye_z_next = EYE_W'(side[ST_OUT-1].tz) - EYE_W'(scl_z);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      eye_x <= sat_coord(eye_x_next);
      eye_y <= sat_coord(eye_y_next);
      eye_z <= sat_coord(eye_z_next);
    end
  end

  assign yaw_out   = side[NSTG-1].yaw;
  assign pitch_out = side[NSTG-1].pitch;

  `OCEP_ASSERT_NEXT(a_item_count, 1'b1,
    $countones(vld) == $past($countones(vld)) + ($past(in_valid && in_ready) ? 1 : 0)
      - ($past(out_valid && out_ready) ? 1 : 0),
    "Pipeline item count does not match accepted and delivered items.")
  `OCEP_ASSERT_NOW(a_empty_out_ready, !out_valid, in_ready,
    "Input not ready although the output stage is empty.")
  `OCEP_ASSERT_NOW(a_yaw_range, out_valid, (yaw_out >= -PI_A) && (yaw_out <= PI_A),
    "Wrapped yaw lies outside the range of minus pi to pi.")

endmodule
